// ----- hdl/ttcd_pkg.sv -----
// Shared constants, types and coefficient tables of the two-tone detector.
package ttcd_pkg;

  localparam int TABLE_LEN = 25;
  localparam int X_BITS    = 10;
  localparam int ACC_BITS  = 32;

  localparam logic [1:0] TONE_LOW  = 2'd0;
  localparam logic [1:0] TONE_HIGH = 2'd1;
  localparam logic [1:0] TONE_NONE = 2'd2;

  typedef logic signed [ACC_BITS-1:0] acc_word_t;

  // Handshake between the sequencer and the serial multiply-accumulate unit.
  typedef struct packed {
    logic start;
    logic clear;
  } mac_ctrl_t;

  // cos(2*pi*k/25) in Q1.14.
  function automatic logic signed [15:0] cos_q14(input logic [4:0] k);
    logic signed [15:0] v;
    case (k)
      5'd0:  v = 16'sd16384;  5'd1:  v = 16'sd15870;  5'd2:  v = 16'sd14357;
      5'd3:  v = 16'sd11944;  5'd4:  v = 16'sd8779;   5'd5:  v = 16'sd5063;
      5'd6:  v = 16'sd1029;   5'd7:  v = -16'sd3070;  5'd8:  v = -16'sd6976;
      5'd9:  v = -16'sd10443; 5'd10: v = -16'sd13255; 5'd11: v = -16'sd15234;
      5'd12: v = -16'sd16255; 5'd13: v = -16'sd16255; 5'd14: v = -16'sd15234;
      5'd15: v = -16'sd13255; 5'd16: v = -16'sd10443; 5'd17: v = -16'sd6976;
      5'd18: v = -16'sd3070;  5'd19: v = 16'sd1029;   5'd20: v = 16'sd5063;
      5'd21: v = 16'sd8779;   5'd22: v = 16'sd11944;  5'd23: v = 16'sd14357;
      5'd24: v = 16'sd15870;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  // sin(2*pi*k/25) in Q1.14.
  function automatic logic signed [15:0] sin_q14(input logic [4:0] k);
    logic signed [15:0] v;
    case (k)
      5'd0:  v = 16'sd0;      5'd1:  v = 16'sd4075;   5'd2:  v = 16'sd7894;
      5'd3:  v = 16'sd11215;  5'd4:  v = 16'sd13833;  5'd5:  v = 16'sd15583;
      5'd6:  v = 16'sd16351;  5'd7:  v = 16'sd16094;  5'd8:  v = 16'sd14824;
      5'd9:  v = 16'sd12624;  5'd10: v = 16'sd9631;   5'd11: v = 16'sd6031;
      5'd12: v = 16'sd2053;   5'd13: v = -16'sd2053;  5'd14: v = -16'sd6031;
      5'd15: v = -16'sd9631;  5'd16: v = -16'sd12624; 5'd17: v = -16'sd14824;
      5'd18: v = -16'sd16094; 5'd19: v = -16'sd16351; 5'd20: v = -16'sd15583;
      5'd21: v = -16'sd13833; 5'd22: v = -16'sd11215; 5'd23: v = -16'sd7894;
      5'd24: v = -16'sd4075;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/ttcd_if.sv -----
// Valid/ready channel interfaces for sample words and tone result words.
interface ttcd_in_if;
  logic       valid;
  logic       ready;
  logic [9:0] sample;
  logic       last;
  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

interface ttcd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] tone;
  modport source (output valid, output tone, input ready);
  modport sink (input valid, input tone, output ready);
endinterface

// ----- hdl/two_tone_correlation_detector.sv -----
// Top level of the two-tone detector: sequencer, phase counters and output register.
// Usage: sample words enter on in_i (valid/ready), each with a last flag that closes
// the window. For every word marked last, one tone word leaves on out_o:
// 0 = 800 Hz, 1 = 1200 Hz, 2 = nothing. Other words give no result.
// reference_level must be written through cfg_we_i/cfg_data_i only while the block
// is idle; the block itself does not enforce this. A sample passes an issue step,
// the bit-serial multiplier (one bit of the sample per cycle) and a saturating
// accumulate step before in_i.ready rises again. A word marked last then passes
// through the energy unit, whose shared squarer takes the four sums one per cycle,
// before its result is valid. Samples beyond MAX_SAMPLES in one window are not
// accumulated and, unless marked last, leave in_i.ready high.
// The result sits in an output register; further samples are accepted while it
// waits. If a new result is ready before the old one is taken, the block holds
// it and stops accepting until out_o.ready frees the register.
// Reset clears the sums, the phase, the sample count, the register and the output.
module two_tone_correlation_detector #(
  parameter int MAX_SAMPLES = 128,
  parameter int COEF_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ttcd_in_if.sink     in_i,
  ttcd_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i
);
  import ttcd_pkg::*;

  localparam int CW = $clog2(MAX_SAMPLES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MAC  = 2'd1;
  localparam logic [1:0] ST_DEC  = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [31:0]   ref_q;
  logic [4:0]    kl_q, kh_q;
  logic [CW-1:0] count_q;
  logic          last_q;
  logic signed [9:0] x_in;
  logic          ov_q;
  logic [1:0]    tone_q, held_q;
  logic          accept, room, mac_done, dec_done, dec_start, load_out;
  logic [1:0]    dec_tone;
  mac_ctrl_t     mac_ctrl;
  acc_word_t     acc [4];
  logic [5:0]    kl_n, kh_n;

  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign room = !ov_q || out_o.ready;
  assign load_out = room && (dec_done || state_q == ST_HOLD);
  assign dec_start = (accept && in_i.last && count_q >= CW'(MAX_SAMPLES)) ||
                     (mac_done && last_q);

  assign mac_ctrl.start = (state_q == ST_IDLE) && accept && (count_q < CW'(MAX_SAMPLES));
  assign mac_ctrl.clear = load_out;

  ttcd_serial_mac #(.COEF_BITS(COEF_BITS)) u_mac (
    .clk_i, .rst_ni, .ctrl_i(mac_ctrl), .x_i(x_in), .kl_i(kl_q), .kh_i(kh_q),
    .done_o(mac_done), .acc_o(acc)
  );

  ttcd_energy #(.COEF_BITS(COEF_BITS)) u_energy (
    .clk_i, .rst_ni, .start_i(dec_start), .acc_i(acc), .ref_i(ref_q),
    .done_o(dec_done), .tone_o(dec_tone)
  );

  // The sample itself enters the multiplier through x_in, so offset removal is a
  // flip of the top bit.
  always_comb begin
    x_in = {~in_i.sample[9], in_i.sample[8:0]};
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (mac_ctrl.start) state_d = ST_MAC;
        else if (dec_start) state_d = ST_DEC;
      end
      ST_MAC:  if (mac_done) state_d = last_q ? ST_DEC : ST_IDLE;
      ST_DEC:  if (dec_done) state_d = room ? ST_IDLE : ST_HOLD;
      ST_HOLD: if (room) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    kl_n = 6'(kl_q) + 6'd2;
    kh_n = 6'(kh_q) + 6'd3;
    if (kl_n >= 6'(TABLE_LEN)) kl_n = kl_n - 6'(TABLE_LEN);
    if (kh_n >= 6'(TABLE_LEN)) kh_n = kh_n - 6'(TABLE_LEN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ref_q   <= '0;
      kl_q    <= '0;
      kh_q    <= '0;
      count_q <= '0;
      last_q  <= 1'b0;
      ov_q    <= 1'b0;
      tone_q  <= TONE_NONE;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) ref_q <= cfg_data_i;
      if (accept) last_q <= in_i.last;
      if (load_out) begin
        kl_q    <= '0;
        kh_q    <= '0;
        count_q <= '0;
      end else if (mac_done) begin
        kl_q    <= kl_n[4:0];
        kh_q    <= kh_n[4:0];
        count_q <= count_q + CW'(1);
      end
      if (load_out) begin
        ov_q   <= 1'b1;
        tone_q <= dec_done ? dec_tone : held_q;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dec_done) held_q <= dec_tone;
  end

  assign out_o.valid = ov_q;
  assign out_o.tone  = tone_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !mac_done && !dec_done)
    else $error("input accepted while an item is in flight");
  a_tone_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.tone != 2'd3)
    else $error("invalid tone code");
  a_dec_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_done |-> state_q == ST_DEC)
    else $error("decision finished outside the decision state");
  a_load_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> out_o.valid)
    else $error("result dropped while stalled");

endmodule

// ----- hdl/ttcd_serial_mac.sv -----
// Bit-serial multiplier of one sample by four coefficients with saturating accumulators.
module ttcd_serial_mac #(
  parameter int COEF_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ttcd_pkg::mac_ctrl_t       ctrl_i,
  input  logic signed [9:0]         x_i,
  input  logic [4:0]                kl_i,
  input  logic [4:0]                kh_i,
  output logic                      done_o,
  output ttcd_pkg::acc_word_t       acc_o [4]
);
  import ttcd_pkg::*;

  localparam int PW  = COEF_BITS + X_BITS;
  localparam int SW  = (PW + 1 > ACC_BITS + 1) ? PW + 1 : ACC_BITS + 1;
  localparam int UP  = (COEF_BITS >= 16) ? COEF_BITS - 16 : 0;
  localparam int DN  = (COEF_BITS < 16) ? 16 - COEF_BITS : 0;
  localparam logic [3:0] LAST_BIT = 4'(X_BITS - 1);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_ACC  = 2'd2;

  localparam logic signed [SW-1:0] SAT_MAX = SW'(64'sh7FFF_FFFF);
  localparam logic signed [SW-1:0] SAT_MIN = -SW'(64'sh8000_0000);

  logic [1:0]               ph_q, ph_d;
  logic [3:0]               cnt_q;
  logic [X_BITS-1:0]        xs_q;
  logic signed [PW-1:0]     cm_q [4];
  logic signed [PW-1:0]     p_q [4];
  acc_word_t                acc_q [4];
  logic signed [COEF_BITS-1:0] coef [4];

  function automatic logic signed [COEF_BITS-1:0] scale(input logic signed [15:0] q);
    logic signed [24:0] w;
    w = ((25'(q)) <<< UP) >>> DN;
    return w[COEF_BITS-1:0];
  endfunction

  always_comb begin
    coef[0] = scale(cos_q14(kl_i));
    coef[1] = scale(sin_q14(kl_i));
    coef[2] = scale(cos_q14(kh_i));
    coef[3] = scale(sin_q14(kh_i));
  end

  always_comb begin
    ph_d = ph_q;
    case (ph_q)
      PH_IDLE: if (ctrl_i.start) ph_d = PH_MUL;
      PH_MUL:  if (cnt_q == LAST_BIT) ph_d = PH_ACC;
      PH_ACC:  ph_d = PH_IDLE;
      default: ph_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_IDLE;
    end else begin
      ph_q <= ph_d;
    end
  end

  // Each cycle one bit of x adds the shifted coefficient; the sign bit subtracts it.
  always_ff @(posedge clk_i) begin
    if (ph_q == PH_IDLE && ctrl_i.start) begin
      xs_q  <= x_i;
      cnt_q <= '0;
      for (int i = 0; i < 4; i++) begin
        cm_q[i] <= PW'(coef[i]);
        p_q[i]  <= '0;
      end
    end else if (ph_q == PH_MUL) begin
      xs_q  <= xs_q >> 1;
      cnt_q <= cnt_q + 4'd1;
      for (int i = 0; i < 4; i++) begin
        cm_q[i] <= cm_q[i] <<< 1;
        if (xs_q[0]) begin
          if (cnt_q == LAST_BIT) p_q[i] <= p_q[i] - cm_q[i];
          else p_q[i] <= p_q[i] + cm_q[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) acc_q[i] <= '0;
    end else if (ctrl_i.clear) begin
      for (int i = 0; i < 4; i++) acc_q[i] <= '0;
    end else if (ph_q == PH_ACC) begin
      for (int i = 0; i < 4; i++) begin
        logic signed [SW-1:0] s;
        s = SW'(acc_q[i]) + SW'(p_q[i]);
        if (s > SAT_MAX) acc_q[i] <= ACC_BITS'(SAT_MAX);
        else if (s < SAT_MIN) acc_q[i] <= ACC_BITS'(SAT_MIN);
        else acc_q[i] <= s[ACC_BITS-1:0];
      end
    end
  end

  assign done_o = (ph_q == PH_ACC);
  always_comb for (int i = 0; i < 4; i++) acc_o[i] = acc_q[i];

endmodule

// ----- hdl/ttcd_energy.sv -----
// Energy of both tones through one shared squarer, then the tone decision.
module ttcd_energy #(
  parameter int COEF_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  ttcd_pkg::acc_word_t acc_i [4],
  input  logic [31:0]         ref_i,
  output logic                done_o,
  output logic [1:0]          tone_o
);
  import ttcd_pkg::*;

  localparam int SH = COEF_BITS - 2;
  localparam int AW = ACC_BITS - SH;
  localparam int EW = 2 * AW + 1;
  localparam int TW = EW + 4;

  logic               busy_q;
  logic [2:0]         step_q;
  logic [2*AW-1:0]    sq_q;
  logic [EW-1:0]      el_q, eh_q;
  logic signed [ACC_BITS-1:0] sh_v;
  logic signed [AW-1:0]       a_v;
  logic [TW-1:0]      ten_l, ten_h;
  logic [1:0]         tone_d;

  always_comb begin
    sh_v = acc_i[step_q[1:0]] >>> SH;
    a_v  = sh_v[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      if (step_q == 3'd5) busy_q <= 1'b0;
      step_q <= step_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      el_q <= '0;
      eh_q <= '0;
    end else if (busy_q) begin
      if (step_q < 3'd4) sq_q <= (2*AW)'(a_v * a_v);
      if (step_q == 3'd1 || step_q == 3'd2) el_q <= el_q + EW'(sq_q);
      if (step_q == 3'd3 || step_q == 3'd4) eh_q <= eh_q + EW'(sq_q);
      if (step_q == 3'd5) tone_o <= tone_d;
    end
  end

  always_comb begin
    ten_l = (TW'(el_q) << 3) + (TW'(el_q) << 1);
    ten_h = (TW'(eh_q) << 3) + (TW'(eh_q) << 1);
    if (el_q > eh_q && ten_l > TW'(ref_i)) tone_d = TONE_LOW;
    else if (eh_q > el_q && ten_h > TW'(ref_i)) tone_d = TONE_HIGH;
    else tone_d = TONE_NONE;
  end

  // Done is registered in the same cycle as the decision, so both are seen together.
  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= busy_q && (step_q == 3'd5);
  end
  assign done_o = done_q;

endmodule

// ----- dv/tb_ttcd_if.sv -----
// Constants shared by the testbench of the two-tone detector.
package tb_ttcd_util_pkg;

  localparam int TB_TABLE_LEN = 25;

endpackage

// ----- dv/tb_two_tone_correlation_detector.sv -----
// Self-checking testbench for the two-tone correlation detector.
module tb_two_tone_correlation_detector;
  timeunit 1ns;
  timeprecision 1ps;
  import ttcd_pkg::*;
  import tb_ttcd_util_pkg::*;

  localparam int MAX_SAMPLES = 128;
  localparam int COEF_BITS   = 16;
  localparam int WATCH_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_data_i = '0;

  ttcd_in_if  in_ch ();
  ttcd_out_if out_ch ();

  two_tone_correlation_detector #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .COEF_BITS(COEF_BITS)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_i(in_ch.sink),
    .out_o(out_ch.source),
    .cfg_we_i(cfg_we_i),
    .cfg_data_i(cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Predictor state.
  logic [31:0]      ref_level;
  int unsigned      phase;
  int unsigned      win_count;
  logic signed [31:0] c_lo, s_lo, c_hi, s_hi;
  logic [1:0]       tone_q[$];

  int  errors = 0;
  int  idle_cycles = 0;
  bit  hold_rx = 1'b0;
  bit  long_gaps = 1'b1;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
  end

  function automatic logic signed [31:0] sat_acc(logic signed [31:0] acc,
                                                 longint prod);
    longint sum;
    sum = longint'(acc) + prod;
    if (sum > 64'sd2147483647) return 32'sh7fffffff;
    if (sum < -64'sd2147483648) return 32'sh80000000;
    return sum[31:0];
  endfunction

  function automatic longint unsigned tone_energy(logic signed [31:0] c,
                                                  logic signed [31:0] s);
    longint a, b;
    a = longint'(c) >>> (COEF_BITS - 2);
    b = longint'(s) >>> (COEF_BITS - 2);
    return longint'(a * a) + longint'(b * b);
  endfunction

  task automatic predict_word(logic [9:0] smp, logic lst);
    longint x;
    int unsigned kl, kh;
    longint unsigned el, eh;
    logic [1:0] t;
    x = longint'(smp) - 512;
    if (win_count < MAX_SAMPLES) begin
      kl = (2 * phase) % TB_TABLE_LEN;
      kh = (3 * phase) % TB_TABLE_LEN;
      c_lo = sat_acc(c_lo, x * longint'(cos_q14(kl[4:0])));
      s_lo = sat_acc(s_lo, x * longint'(sin_q14(kl[4:0])));
      c_hi = sat_acc(c_hi, x * longint'(cos_q14(kh[4:0])));
      s_hi = sat_acc(s_hi, x * longint'(sin_q14(kh[4:0])));
      phase = (phase + 1) % TB_TABLE_LEN;
      win_count++;
    end
    if (lst) begin
      el = tone_energy(c_lo, s_lo);
      eh = tone_energy(c_hi, s_hi);
      t = TONE_NONE;
      if (el > eh && el * 10 > longint'(ref_level)) t = TONE_LOW;
      else if (eh > el && eh * 10 > longint'(ref_level)) t = TONE_HIGH;
      tone_q.push_back(t);
      phase = 0;
      win_count = 0;
      c_lo = '0; s_lo = '0; c_hi = '0; s_hi = '0;
    end
  endtask

  // Valid drops only when a real gap follows, so it is never assigned twice in
  // one time step.
  task automatic random_gap();
    int n;
    n = $urandom_range(0, 9) == 0 ? $urandom_range(0, long_gaps ? 30 : 3) : 0;
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Sends one word and holds valid until it is taken.
  task automatic send_word(logic [9:0] smp, logic lst);
    in_ch.valid <= 1'b1;
    in_ch.sample <= smp;
    in_ch.last <= lst;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_word(smp, lst);
    random_gap();
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (tone_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_ref(logic [31:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ref_level = v;
    @(posedge clk_i);
  endtask

  // A window of a pure tone at one of the two frequencies plus noise.
  task automatic send_tone_window(int len, int which, int amp);
    int k, v;
    for (int n = 0; n < len; n++) begin
      k = ((which ? 3 : 2) * n) % TB_TABLE_LEN;
      v = 512 + (amp * cos_q14(k[4:0])) / 16384 + int'($urandom_range(0, 8)) - 4;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      send_word(v[9:0], n == len - 1);
    end
  endtask

  task automatic test_directed();
    send_word(10'd512, 1'b1);
    send_word(10'd0, 1'b0);
    send_word(10'd1023, 1'b1);
    send_word(10'd0, 1'b1);
    send_word(10'h155, 1'b0);
    send_word(10'h2aa, 1'b1);
    send_tone_window(25, 0, 500);
    send_tone_window(25, 1, 500);
  endtask

  task automatic test_saturation();
    // Long windows of extreme values, past MAX_SAMPLES.
    for (int n = 0; n < MAX_SAMPLES + 20; n++)
      send_word(10'd0, n == MAX_SAMPLES + 19);
    for (int n = 0; n < MAX_SAMPLES + 5; n++)
      send_word(10'd1023, n == MAX_SAMPLES + 4);
  endtask

  task automatic test_reference_levels();
    write_ref(32'hffffffff);
    send_tone_window(50, 0, 511);
    send_tone_window(50, 1, 511);
    write_ref(32'd1000);
    send_tone_window(25, 0, 40);
    send_tone_window(25, 1, 3);
    write_ref(32'd0);
  endtask

  task automatic test_backpressure();
    hold_rx = 1'b1;
    for (int w = 0; w < 4; w++) send_word(10'($urandom_range(0, 1023)), 1'b1);
    hold_rx = 1'b0;
    drain();
  endtask

  task automatic test_random();
    int sent, len, kind;
    sent = 0;
    while (sent < 940) begin
      if (sent > 600 && ref_level == 0) write_ref($urandom());
      kind = $urandom_range(0, 9);
      len = $urandom_range(1, 40);
      if (kind < 6) send_tone_window(len, kind & 1, $urandom_range(0, 511));
      else
        for (int n = 0; n < len; n++)
          send_word(10'($urandom_range(0, 1023)), n == len - 1);
      sent += len;
      long_gaps = $urandom_range(0, 3) != 0;
    end
    long_gaps = 1'b1;
  endtask

  // Result checker and receiver stalls.
  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready) begin
      if (tone_q.size() == 0) begin
        $display("%0t: unexpected tone word, expected none, actual %0d", $time,
                 out_ch.tone);
        errors++;
      end else begin
        if (out_ch.tone !== tone_q[0]) begin
          $display("%0t: tone mismatch, expected %0d, actual %0d", $time,
                   tone_q[0], out_ch.tone);
          errors++;
        end
        void'(tone_q.pop_front());
      end
    end
  end

  initial begin
    int hold;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_rx) begin
        out_ch.ready <= 1'b0;
        hold = 0;
        while (hold < 150) begin
          @(posedge clk_i);
          hold++;
        end
        out_ch.ready <= 1'b1;
        while (hold_rx) @(posedge clk_i);
      end else begin
        out_ch.ready <= ($urandom_range(0, 3) != 0) || !long_gaps;
      end
    end
  end

  // Watchdog on cycles where no word moves.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    ref_level = '0;
    phase = 0;
    win_count = 0;
    c_lo = '0; s_lo = '0; c_hi = '0; s_hi = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_saturation();
    test_reference_levels();
    test_backpressure();
    test_random();
    drain();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
